/* rtl/core/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/pmt_pkg.sv */
// ============================================================================
// pmt_pkg
// Types, sizes and helpers for the permutation move tracker.
// ============================================================================
`default_nettype none

package pmt_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_MOVES  = 32;

    // Port field widths
    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 5;
    localparam int POINT_W  = 6;
    localparam int CFG_W    = 7;
    localparam int STATUS_W = 2;

    // APB
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Derived storage sizes
    localparam int TRK_AW    = $clog2(MAX_POINTS);
    localparam int TRK_DW    = TRK_AW;
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int MV_AW     = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;
    localparam int TBL_DEPTH = MAX_MOVES * MAX_POINTS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    localparam logic [CFG_W-1:0]    CFG_RESET       = CFG_W'(64);
    localparam logic [APB_AW-3:0]   REG_POINT_COUNT = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR,
        CMD_LOAD,
        CMD_RESTART,
        CMD_APPLY,
        CMD_SAVE,
        CMD_READ
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_UNKNOWN,
        ST_REFUSED,
        ST_RANGE
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_SAVE,
        S_READ,
        S_RESP
    } t_state;

    // Flat move table address: slot * MAX_POINTS + point
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [TRK_AW-1:0] pt);
        tbl_addr = TBL_AW'(32'(slot) * MAX_POINTS + 32'(pt));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pmt_ram.sv */
// ============================================================================
// pmt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module pmt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/permutation_move_tracker_unit.sv */
// ============================================================================
// permutation_move_tracker_unit
// Move table plus tracking permutation; loads, applies, saves and reads moves.
// ============================================================================
//
//  Channel  Dir  Handshake                  Payload
//  -------  ---  -------------------------  -------------------------------
//  in       in   i_in_valid / o_in_stall    command, move_index, point,
//                                           value, last_entry
//  out      out  o_out_valid / i_out_stall  status, position
//  cfg      in   APB (psel/penable/pready)  point_count at address 0
//
//  An accepted beat reaches o_out_valid through S_RESP; a valid apply or save
//  first loops over n = point_count clamped to 1..64, a read passes S_READ.
//  Apply moves one point per cycle through a read/lookup/write loop.
//  One item in flight; o_in_stall drops with the result.
//  Reset is synchronous; tracking reset uses per-entry valid bits, so no
//  clearing pass. A stalled result holds in the output register.
// ============================================================================
`default_nettype none

module permutation_move_tracker_unit
    import pmt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [SLOT_W-1:0]   i_move_index,
    input  logic [POINT_W-1:0]  i_point,
    input  logic [POINT_W-1:0]  i_value,
    input  logic                i_last_entry,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [POINT_W-1:0]  o_position,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_point_count, n_point_count;
    logic [MAX_MOVES-1:0]   r_known, n_known;
    logic [MAX_POINTS-1:0]  r_trk_vld, n_trk_vld;
    logic                   r_unk, n_unk;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [POINT_W-1:0]     r_pt, n_pt;
    t_status                r_status, n_status;
    logic [POINT_W-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_p1_vld, n_p1_vld;
    logic                   r_p2_vld, n_p2_vld;
    logic [TRK_AW-1:0]      r_p1_idx, n_p1_idx;
    logic [TRK_AW-1:0]      r_p2_idx, n_p2_idx;
    logic                   r_out_vld, n_out_vld;
    t_status                r_out_status, n_out_status;
    logic [POINT_W-1:0]     r_out_pos, n_out_pos;

    logic [CNT_W-1:0]       cnt;
    t_cmd                   cmd;
    logic                   in_acc;
    logic                   cfg_wr;
    logic                   out_free;
    logic                   slot_bad;
    logic                   pt_bad;
    logic                   val_bad;
    logic                   issue;
    logic                   apply_done;
    logic                   save_done;
    logic [TRK_DW-1:0]      loop_img;
    logic [TRK_DW-1:0]      read_img;

    logic                   trk_we;
    logic [TRK_AW-1:0]      trk_waddr;
    logic [TRK_DW-1:0]      trk_wdata;
    logic [TRK_AW-1:0]      trk_raddr;
    logic [TRK_DW-1:0]      trk_rdata;
    logic                   mv_we;
    logic [TBL_AW-1:0]      mv_waddr;
    logic [TRK_DW-1:0]      mv_wdata;
    logic [TBL_AW-1:0]      mv_raddr;
    logic [TRK_DW-1:0]      mv_rdata;

    pmt_ram #(.WIDTH(TRK_DW), .DEPTH(MAX_POINTS)) u_trk_ram (
        .i_clk   (i_clk),
        .i_we    (trk_we),
        .i_waddr (trk_waddr),
        .i_wdata (trk_wdata),
        .i_raddr (trk_raddr),
        .o_rdata (trk_rdata)
    );

    pmt_ram #(.WIDTH(TRK_DW), .DEPTH(TBL_DEPTH)) u_move_ram (
        .i_clk   (i_clk),
        .i_we    (mv_we),
        .i_waddr (mv_waddr),
        .i_wdata (mv_wdata),
        .i_raddr (mv_raddr),
        .o_rdata (mv_rdata)
    );

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    always_comb begin
        if (r_point_count == '0) begin
            cnt = CNT_W'(1);
        end else if (32'(r_point_count) > MAX_POINTS) begin
            cnt = CNT_W'(MAX_POINTS);
        end else begin
            cnt = CNT_W'(r_point_count);
        end
    end

    assign cmd        = t_cmd'(i_command);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cfg_wr     = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_POINT_COUNT);
    assign out_free   = !r_out_vld || !i_out_stall;
    assign slot_bad   = (32'(i_move_index) >= MAX_MOVES);
    assign pt_bad     = (32'(i_point) >= 32'(cnt));
    assign val_bad    = (32'(i_value) >= 32'(cnt));

    assign issue      = (r_idx < cnt);
    assign apply_done = !issue && !r_p1_vld && !r_p2_vld;
    assign save_done  = !issue && !r_p1_vld;

    // Unwritten tracking entries read as their own index
    assign loop_img = r_trk_vld[r_p1_idx] ? trk_rdata : TRK_DW'(r_p1_idx);
    assign read_img = r_trk_vld[TRK_AW'(r_pt)] ? trk_rdata : TRK_DW'(r_pt);

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_POINT_COUNT) ? APB_DW'(r_point_count) : '0;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (cmd)
                        CMD_APPLY: begin
                            n_state = (!slot_bad && r_known[MV_AW'(i_move_index)]) ?
                                      S_APPLY : S_RESP;
                        end
                        CMD_SAVE: begin
                            n_state = (!slot_bad && !r_unk) ? S_SAVE : S_RESP;
                        end
                        CMD_READ: begin
                            n_state = pt_bad ? S_RESP : S_READ;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_APPLY: begin
                if (apply_done) n_state = S_RESP;
            end
            S_SAVE: begin
                if (save_done) n_state = S_RESP;
            end
            S_READ: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb begin
        n_point_count = r_point_count;
        n_known       = r_known;
        n_trk_vld     = r_trk_vld;
        n_unk         = r_unk;
        n_slot        = r_slot;
        n_pt          = r_pt;
        n_status      = r_status;
        n_pos         = r_pos;
        n_idx         = r_idx;
        n_p1_vld      = 1'b0;
        n_p1_idx      = r_p1_idx;
        n_p2_vld      = 1'b0;
        n_p2_idx      = r_p2_idx;
        n_out_vld     = r_out_vld && i_out_stall;
        n_out_status  = r_out_status;
        n_out_pos     = r_out_pos;

        trk_we    = 1'b0;
        trk_waddr = r_p2_idx;
        trk_wdata = mv_rdata;
        trk_raddr = (r_state == S_IDLE) ? TRK_AW'(i_point) : r_idx[TRK_AW-1:0];
        mv_we     = 1'b0;
        mv_waddr  = tbl_addr(i_move_index, TRK_AW'(i_point));
        mv_wdata  = TRK_DW'(i_value);
        mv_raddr  = tbl_addr(r_slot, loop_img);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_slot   = i_move_index;
                    n_pt     = i_point;
                    n_status = ST_OK;
                    n_pos    = '0;
                    n_idx    = '0;
                    case (cmd)
                        CMD_CLEAR: begin
                            n_known = '0;
                        end
                        CMD_LOAD: begin
                            if (slot_bad || pt_bad || val_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                mv_we = 1'b1;
                                if (i_last_entry) n_known[MV_AW'(i_move_index)] = 1'b1;
                            end
                        end
                        CMD_RESTART: begin
                            n_trk_vld = '0;
                            n_unk     = 1'b0;
                        end
                        CMD_APPLY: begin
                            if (slot_bad) begin
                                n_status = ST_RANGE;
                                n_unk    = 1'b1;
                            end else if (!r_known[MV_AW'(i_move_index)]) begin
                                n_status = ST_UNKNOWN;
                                n_unk    = 1'b1;
                            end
                        end
                        CMD_SAVE: begin
                            if (slot_bad) begin
                                n_status = ST_RANGE;
                            end else if (r_unk) begin
                                n_status = ST_REFUSED;
                            end else begin
                                n_known[MV_AW'(i_move_index)] = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            if (pt_bad) n_status = ST_RANGE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // read tracking[i] -> look up move[t] -> write tracking[i]
            S_APPLY: begin
                n_p1_vld = issue;
                n_p1_idx = r_idx[TRK_AW-1:0];
                if (issue) n_idx = r_idx + CNT_W'(1);
                n_p2_vld = r_p1_vld;
                n_p2_idx = r_p1_idx;
                if (r_p2_vld) begin
                    trk_we              = 1'b1;
                    n_trk_vld[r_p2_idx] = 1'b1;
                end
            end
            // read tracking[i] -> write move[slot][i]
            S_SAVE: begin
                n_p1_vld = issue;
                n_p1_idx = r_idx[TRK_AW-1:0];
                if (issue) n_idx = r_idx + CNT_W'(1);
                if (r_p1_vld) begin
                    mv_we    = 1'b1;
                    mv_waddr = tbl_addr(r_slot, r_p1_idx);
                    mv_wdata = loop_img;
                end
            end
            S_READ: begin
                n_pos = POINT_W'(read_img);
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = r_pos;
                end
            end
            default: begin
            end
        endcase

        // register write forgets all moves and restarts tracking
        if (cfg_wr) begin
            n_point_count = pwdata[CFG_W-1:0];
            n_known       = '0;
            n_trk_vld     = '0;
            n_unk         = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= CFG_RESET;
            r_known       <= '0;
            r_trk_vld     <= '0;
            r_unk         <= 1'b0;
            r_p1_vld      <= 1'b0;
            r_p2_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_point_count <= n_point_count;
            r_known       <= n_known;
            r_trk_vld     <= n_trk_vld;
            r_unk         <= n_unk;
            r_p1_vld      <= n_p1_vld;
            r_p2_vld      <= n_p2_vld;
            r_out_vld     <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_pt         <= n_pt;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_p1_idx     <= n_p1_idx;
        r_p2_idx     <= n_p2_idx;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_out_status;
    assign o_position  = r_out_pos;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_CLK(a_acc_leaves_idle,
                in_acc |=> (r_state != S_IDLE),
                "beat accepted but sequencer stayed idle")
    `ASSERT_CLK(a_wb_only_apply,
                r_p2_vld |-> (r_state == S_APPLY),
                "tracking write-back outside apply")
    `ASSERT_CLK(a_resp_drained,
                (r_state == S_RESP) |-> (!r_p1_vld && !r_p2_vld),
                "loop pipeline not drained at response")
    `ASSERT_CLK(a_cfg_restart,
                cfg_wr |=> (!r_unk && (r_trk_vld == '0) && (r_known == '0)),
                "register write did not restart tracking")
    `ASSERT_CLK_ALWAYS(a_rst_idle,
                       !i_rst_n |=> ((r_state == S_IDLE) && !r_out_vld),
                       "reset did not return to idle")

endmodule

`default_nettype wire

/* dv/permutation_move_tracker_unit_tb.sv */
// ============================================================================
// permutation_move_tracker_unit_tb
// Self-checking bench: drives move loads, applies, saves and reads through
// the command channel under random idle/stall, predicts each result from a
// shadow move table and tracking permutation, and sweeps point_count over
// APB across small, clamped and full-size settings.
// ============================================================================

module permutation_move_tracker_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pmt_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TOTAL_ITEMS  = 1600;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_PCT     = 33;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SLOT_W-1:0]  slot;
        logic [POINT_W-1:0] point;
        logic [POINT_W-1:0] value;
        logic               last;
    } t_move_cmd;

    typedef struct packed {
        t_status            status;
        logic [POINT_W-1:0] position;
    } t_tracker_result;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command    = '0;
    logic [SLOT_W-1:0]   i_move_index = '0;
    logic [POINT_W-1:0]  i_point      = '0;
    logic [POINT_W-1:0]  i_value      = '0;
    logic                i_last_entry = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [POINT_W-1:0]  o_position;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [APB_AW-1:0]   paddr        = '0;
    logic [APB_DW-1:0]   pwdata       = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    permutation_move_tracker_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_move_index (i_move_index),
        .i_point      (i_point),
        .i_value      (i_value),
        .i_last_entry (i_last_entry),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_position   (o_position),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow state of the tracker
    // ------------------------------------------------------------------------
    logic [POINT_W-1:0] move_tbl    [MAX_MOVES*MAX_POINTS];
    bit                 tbl_written [MAX_MOVES*MAX_POINTS];
    bit                 slot_known  [MAX_MOVES];
    logic [POINT_W-1:0] trk_perm    [MAX_POINTS];
    bit                 unknown_seen;
    logic [CFG_W-1:0]   points_reg;

    t_move_cmd       queued_cmds[$];
    t_tracker_result awaited_results[$];

    int  cycle_cnt    = 0;
    int  error_cnt    = 0;
    int  items_queued = 0;
    bit  calm         = 1'b0;   // no idling on either side while set

    function automatic int active_points();
        if (points_reg == 0) return 1;
        if (points_reg > MAX_POINTS) return MAX_POINTS;
        return int'(points_reg);
    endfunction

    function automatic void restart_tracking();
        int i;
        for (i = 0; i < MAX_POINTS; i++) trk_perm[i] = POINT_W'(i);
        unknown_seen = 1'b0;
    endfunction

    function automatic void clear_known();
        int i;
        for (i = 0; i < MAX_MOVES; i++) slot_known[i] = 1'b0;
    endfunction

    // Register write side effects: moves forgotten, tracking from identity
    function automatic void set_point_count(input logic [CFG_W-1:0] v);
        points_reg = v;
        clear_known();
        restart_tracking();
    endfunction

    // True when applying this slot touches only table entries already written
    function automatic bit apply_defined(input logic [SLOT_W-1:0] slot);
        int i, n;
        n = active_points();
        for (i = 0; i < n; i++)
            if (!tbl_written[int'(slot)*MAX_POINTS + int'(trk_perm[i])]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic track_step(input t_move_cmd c);
        int              n, base, i;
        t_tracker_result r;
        n    = active_points();
        base = int'(c.slot) * MAX_POINTS;   // slot field cannot exceed MAX_MOVES-1
        r.status   = ST_OK;
        r.position = '0;
        case (c.command)
            CMD_CLEAR: clear_known();
            CMD_LOAD: begin
                if (c.point >= n || c.value >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    move_tbl[base + c.point]    = c.value;
                    tbl_written[base + c.point] = 1'b1;
                    if (c.last) slot_known[c.slot] = 1'b1;
                end
            end
            CMD_RESTART: restart_tracking();
            CMD_APPLY: begin
                if (!slot_known[c.slot]) begin
                    r.status     = ST_UNKNOWN;
                    unknown_seen = 1'b1;
                end else begin
                    for (i = 0; i < n; i++)
                        trk_perm[i] = move_tbl[base + int'(trk_perm[i])];
                end
            end
            CMD_SAVE: begin
                if (unknown_seen) begin
                    r.status = ST_REFUSED;
                end else begin
                    for (i = 0; i < n; i++) begin
                        move_tbl[base + i]    = trk_perm[i];
                        tbl_written[base + i] = 1'b1;
                    end
                    slot_known[c.slot] = 1'b1;
                end
            end
            CMD_READ: begin
                if (c.point >= n) r.status = ST_RANGE;
                else r.position = trk_perm[c.point];
            end
            default: ;
        endcase
        awaited_results = {awaited_results, r};
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // ------------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_move_cmd c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                c.command = i_command;
                c.slot    = i_move_index;
                c.point   = i_point;
                c.value   = i_value;
                c.last    = i_last_entry;
                track_step(c);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (queued_cmds.size() != 0 && !idle_now()) begin
                    c = queued_cmds.pop_front();
                    i_command    <= c.command;
                    i_move_index <= c.slot;
                    i_point      <= c.point;
                    i_value      <= c.value;
                    i_last_entry <= c.last;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tracker_result exp_r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result beat status=%0d position=%0d",
                             $realtime, o_status, o_position);
                    error_cnt++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (o_status !== exp_r.status) begin
                        $display("%0t: status mismatch expected=%0d actual=%0d",
                                 $realtime, exp_r.status, o_status);
                        error_cnt++;
                    end
                    if (o_position !== exp_r.position) begin
                        $display("%0t: position mismatch expected=%0d actual=%0d",
                                 $realtime, exp_r.position, o_position);
                        error_cnt++;
                    end
                end
            end
            i_out_stall <= idle_now();
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_move_cmd make_cmd(input logic [CMD_W-1:0] cmd,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [POINT_W-1:0] pt);
        t_move_cmd c;
        c.command = cmd;
        c.slot    = slot;
        c.point   = pt;
        c.value   = POINT_W'($urandom);
        c.last    = 1'($urandom);
        return c;
    endfunction

    task automatic push_cmd(input t_move_cmd c);
        queued_cmds = {queued_cmds, c};
        items_queued++;
    endtask

    task automatic wait_accepted();
        @(negedge i_clk);
        while (queued_cmds.size() != 0 || i_in_valid) @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        while (queued_cmds.size() != 0 || i_in_valid || awaited_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Apply only once the shadow state is current, so that a known but
    // partly loaded move never reaches the table; such a move is read instead.
    task automatic push_apply(input t_move_cmd c);
        wait_accepted();
        c.command = CMD_APPLY;
        if (slot_known[c.slot] && !apply_defined(c.slot)) c.command = CMD_READ;
        push_cmd(c);
    endtask

    // Full move: every entry below the count, in shuffled order, last flag on
    // the final beat. Images form a permutation or are arbitrary in-range values.
    task automatic load_move(input logic [SLOT_W-1:0] slot, input bit as_perm);
        int        n, i, j, tmp;
        int        img   [MAX_POINTS];
        int        order [MAX_POINTS];
        t_move_cmd c;
        n = active_points();
        for (i = 0; i < n; i++) begin
            img[i]   = as_perm ? i : $urandom_range(n - 1);
            order[i] = i;
        end
        for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = img[i];   img[i]   = img[j];   img[j]   = tmp;
            j = $urandom_range(i);
            tmp = order[i]; order[i] = order[j]; order[j] = tmp;
        end
        for (i = 0; i < n; i++) begin
            c       = make_cmd(CMD_LOAD, slot, POINT_W'(order[i]));
            c.value = POINT_W'(img[order[i]]);
            c.last  = (i == n - 1);
            push_cmd(c);
        end
    endtask

    task automatic apb_write_points(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_POINT_COUNT, 2'b00};
        pwdata  <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        set_point_count(v);
        // read back
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        if (prdata !== APB_DW'(v)) begin
            $display("%0t: point_count readback mismatch expected=%0d actual=%0d",
                     $realtime, v, prdata);
            error_cnt++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(99) < 80) return SLOT_W'($urandom_range(3));
        return SLOT_W'($urandom_range(MAX_MOVES - 1));
    endfunction

    task automatic random_phase(input int budget);
        int        start, n, r;
        bit        paused;
        t_move_cmd c;
        start  = items_queued;
        paused = 1'b0;
        n      = active_points();
        while (items_queued - start < budget) begin
            r = $urandom_range(99);
            if (!paused && items_queued - start > budget / 2) begin
                wait_quiet();
                paused = 1'b1;
            end
            if (r < ((n > 16) ? 8 : 30)) begin
                load_move(pick_slot(), $urandom_range(3) != 0);
            end else if (r < 55) begin
                push_apply(make_cmd(CMD_APPLY, pick_slot(), POINT_W'($urandom)));
            end else if (r < 70) begin
                push_cmd(make_cmd(CMD_READ, SLOT_W'($urandom),
                                  ($urandom_range(4) != 0) ? POINT_W'($urandom_range(n - 1))
                                                           : POINT_W'($urandom)));
            end else if (r < 78) begin
                push_cmd(make_cmd(CMD_SAVE, pick_slot(), POINT_W'($urandom)));
            end else if (r < 84) begin
                push_cmd(make_cmd(CMD_RESTART, SLOT_W'($urandom), POINT_W'($urandom)));
            end else if (r < 87) begin
                push_cmd(make_cmd(CMD_CLEAR, SLOT_W'($urandom), POINT_W'($urandom)));
            end else begin
                // noise: any command, any field values
                c = make_cmd(CMD_W'($urandom), SLOT_W'($urandom), POINT_W'($urandom));
                if (c.command == CMD_APPLY) push_apply(c);
                else push_cmd(c);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] phase_points [12] = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd5, 7'd8,
                                            7'd16, 7'd0, 7'd127, 7'd100, 7'd6, 7'd64};

    initial begin
        t_move_cmd c;
        int        p, budget;
        for (p = 0; p < MAX_MOVES*MAX_POINTS; p++) tbl_written[p] = 1'b0;
        set_point_count(CFG_RESET);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, full point count from reset
        push_cmd(make_cmd(CMD_READ, 5'd0, 6'd0));
        push_cmd(make_cmd(CMD_READ, 5'd31, 6'd63));
        push_cmd(make_cmd(CMD_W'(6), SLOT_W'($urandom), POINT_W'($urandom)));
        push_cmd(make_cmd(CMD_W'(7), SLOT_W'($urandom), POINT_W'($urandom)));
        push_apply(make_cmd(CMD_APPLY, 5'd5, 6'd0));            // never loaded
        push_cmd(make_cmd(CMD_SAVE, 5'd2, 6'd0));               // refused
        push_cmd(make_cmd(CMD_RESTART, 5'd0, 6'd0));
        push_cmd(make_cmd(CMD_SAVE, 5'd31, 6'd0));              // identity into slot 31
        push_apply(make_cmd(CMD_APPLY, 5'd31, 6'd0));
        push_cmd(make_cmd(CMD_CLEAR, 5'd0, 6'd0));
        push_apply(make_cmd(CMD_APPLY, 5'd31, 6'd0));           // forgotten by clear
        push_cmd(make_cmd(CMD_RESTART, 5'd0, 6'd0));

        // Directed, four points
        wait_quiet();
        apb_write_points(7'd4);
        push_apply(make_cmd(CMD_APPLY, 5'd31, 6'd0));           // forgotten by reg write
        push_cmd(make_cmd(CMD_RESTART, 5'd0, 6'd0));
        c = make_cmd(CMD_LOAD, 5'd0, 6'd4); c.value = 6'd1;  c.last = 1'b1;
        push_cmd(c);                                            // point out of range
        c = make_cmd(CMD_LOAD, 5'd0, 6'd1); c.value = 6'd63; c.last = 1'b1;
        push_cmd(c);                                            // image out of range
        push_apply(make_cmd(CMD_APPLY, 5'd0, 6'd0));            // bad loads left it unknown
        push_cmd(make_cmd(CMD_RESTART, 5'd0, 6'd0));
        push_cmd(make_cmd(CMD_READ, 5'd0, 6'd4));
        push_cmd(make_cmd(CMD_READ, 5'd0, 6'd3));
        load_move(5'd1, 1'b1);
        push_apply(make_cmd(CMD_APPLY, 5'd1, 6'd0));
        push_cmd(make_cmd(CMD_READ, 5'd0, 6'd0));
        push_cmd(make_cmd(CMD_SAVE, 5'd30, 6'd0));

        budget = TOTAL_ITEMS / 12;
        for (p = 0; p < 12; p++) begin
            wait_quiet();
            apb_write_points(phase_points[p]);
            calm = (p == 4 || p == 9);
            random_phase(budget);
        end
        calm = 1'b0;

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pmt_pkg.sv
rtl/core/pmt_ram.sv
rtl/core/permutation_move_tracker_unit.sv
dv/permutation_move_tracker_unit_tb.sv
